FILE: rtl/core/bcl_pkg.sv
// ----------------------------------------------------------------------------
// bcl_pkg: shared types and constants of the LRU block buffer cache
// Widths, request/result codes, the per-entry record held by each cell and
// the control word that steps the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bcl_pkg;

   // sizing
   localparam int NUM_ENTRIES = 32;
   localparam int NUM_DEVICES = 4;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int CNT_W       = 6;
   localparam int LBA_W       = 48;
   localparam int BLK_W       = 32;
   localparam int DEV_W       = 7;
   localparam int ID_W        = 8;
   localparam int SLOT_W      = 5;
   localparam int KIND_W      = 3;
   localparam int ERR_W       = 2;
   localparam int REQ_W       = 3;
   localparam int REF_W       = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;

   // request codes
   localparam logic [REQ_W-1:0] REQ_GET     = 3'd0;
   localparam logic [REQ_W-1:0] REQ_READ    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DIRTY   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd3;
   localparam logic [REQ_W-1:0] REQ_SYNC    = 3'd4;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_GRANT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WB    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RD    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ACK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SYNC  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERR   = 3'd5;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_NO_FREE = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NO_DEV  = 2'd2;

   // register map: slot ids first, then slot bases
   localparam logic [CSR_IDX_W-1:0] CSR_DEV0_ID   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEV0_BASE = 3'd4;

   localparam logic [ID_W-1:0] DEV_UNUSED = 8'hFF;

   // one buffer entry, as held by a cell
   typedef struct packed {
      logic [IDX_W-1:0] id;
      logic             tvalid;
      logic [DEV_W-1:0] tdev;
      logic [BLK_W-1:0] tblk;
      logic [LBA_W-1:0] lba;
      logic             dvalid;
      logic             ddirty;
      logic [REF_W-1:0] cnt;
   } entry_type;

   // chain step: every cell below ins_pos takes its neighbour, the cell at
   // ins_pos takes the (updated) head entry
   typedef struct packed {
      logic             step;
      logic [IDX_W-1:0] ins_pos;
   } cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/core/bcl_if.sv
// ----------------------------------------------------------------------------
// bcl_if: request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcl_req_if;
   logic                          valid;
   logic                          ready;
   logic [bcl_pkg::REQ_W-1:0]     req_type;
   logic [bcl_pkg::DEV_W-1:0]     device;
   logic [bcl_pkg::BLK_W-1:0]     block_number;
   logic [bcl_pkg::SLOT_W-1:0]    entry_index;

   modport source (output valid, req_type, device, block_number, entry_index,
                   input ready);
   modport sink   (input valid, req_type, device, block_number, entry_index,
                   output ready);
endinterface

interface bcl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bcl_pkg::KIND_W-1:0]    kind;
   logic [bcl_pkg::SLOT_W-1:0]    entry_slot;
   logic [bcl_pkg::LBA_W-1:0]     io_lba;
   logic [bcl_pkg::CNT_W-1:0]     dirty_count;
   logic [bcl_pkg::ERR_W-1:0]     error_code;
   logic                          last;

   modport source (output valid, kind, entry_slot, io_lba, dirty_count,
                   error_code, last, input ready);
   modport sink   (input valid, kind, entry_slot, io_lba, dirty_count,
                   error_code, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bcl_cell.sv
// ----------------------------------------------------------------------------
// bcl_cell: one position of the recency chain
// Holds the entry at its position; on a step it takes its neighbour's entry
// or, at the insert position, the updated head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module bcl_cell (
   input  wire                            clock,
   input  wire                            reset,
   input  wire [bcl_pkg::IDX_W-1:0]       cell_idx,
   input  wire bcl_pkg::cell_ctl_type     ctl,
   input  wire bcl_pkg::entry_type        nxt_in,
   input  wire bcl_pkg::entry_type        head_in,
   output bcl_pkg::entry_type             ent_out
);

   bcl_pkg::entry_type ent_ff;
   bcl_pkg::entry_type ent_in;

   // next entry at this position
   always_comb begin
      ent_in = ent_ff;
      if (ctl.step) begin
         if (cell_idx == ctl.ins_pos) begin
            ent_in = head_in;
         end else if (cell_idx < ctl.ins_pos) begin
            ent_in = nxt_in;
         end
      end
   end

   // front of chain holds the highest entry at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.id     <= bcl_pkg::IDX_W'(bcl_pkg::NUM_ENTRIES - 1) - cell_idx;
         ent_ff.tvalid <= 1'b0;
         ent_ff.dvalid <= 1'b0;
         ent_ff.ddirty <= 1'b0;
         ent_ff.cnt    <= '0;
      end else begin
         ent_ff <= ent_in;
      end
   end

   assign ent_out = ent_ff;

endmodule

`default_nettype wire

FILE: rtl/core/block_buffer_cache_lru.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru: tag and LRU policy engine of a buffer cache
// Sequencer around a chain of cells that holds the entries in recency order.
// ----------------------------------------------------------------------------
// The entries sit in a chain of cells, front of the recency list at cell 0.
// Every valid request code walks the chain by rotating it one cell per cycle
// past the head cell, where the request's update is applied (sync may hold the
// rotation). Mark dirty and release take one pass over all NUM_ENTRIES cells
// plus accept and response; a release to zero count re-inserts the entry at
// the front during that pass. Sync takes the same pass, stalling while a
// write-back beat waits on the response side. Get and read take a lookup pass
// and an update pass, then up to three response beats; a miss that ends in an
// error skips the update pass.
// One request is in flight at a time; the response register lets the last
// beat wait while the next request is accepted. Config writes take effect
// at once and must only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module block_buffer_cache_lru (
   input  wire                                 clock,
   input  wire                                 reset,
   bcl_req_if.sink                             req_chan,
   bcl_rsp_if.source                           rsp_chan,
   input  wire                                 csr_wr_en,
   input  wire [bcl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [bcl_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int N     = bcl_pkg::NUM_ENTRIES;
   localparam int IDX_W = bcl_pkg::IDX_W;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SCAN      = 7'b0000010,
      ST_APPLY     = 7'b0000100,
      ST_EMIT_WB   = 7'b0001000,
      ST_EMIT_RD   = 7'b0010000,
      ST_EMIT_LAST = 7'b0100000,
      ST_UPD       = 7'b1000000
   } state_type;

   // device slot registers
   logic [bcl_pkg::ID_W-1:0]  dev_id_ff   [bcl_pkg::NUM_DEVICES];
   logic [bcl_pkg::LBA_W-1:0] dev_base_ff [bcl_pkg::NUM_DEVICES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < bcl_pkg::NUM_DEVICES; s++) begin
            dev_id_ff[s]   <= bcl_pkg::DEV_UNUSED;
            dev_base_ff[s] <= '0;
         end
      end else if (csr_wr_en) begin
         for (int s = 0; s < bcl_pkg::NUM_DEVICES; s++) begin
            if (csr_index == bcl_pkg::CSR_DEV0_ID + bcl_pkg::CSR_IDX_W'(s)) begin
               dev_id_ff[s] <= csr_wdata[bcl_pkg::ID_W-1:0];
            end
            if (csr_index == bcl_pkg::CSR_DEV0_BASE + bcl_pkg::CSR_IDX_W'(s)) begin
               dev_base_ff[s] <= csr_wdata[bcl_pkg::LBA_W-1:0];
            end
         end
      end
   end

   // device lookup on the incoming beat, first matching slot wins
   logic                      dev_hit;
   logic [bcl_pkg::LBA_W-1:0] dev_base;

   always_comb begin
      dev_hit  = 1'b0;
      dev_base = '0;
      for (int s = bcl_pkg::NUM_DEVICES - 1; s >= 0; s--) begin
         if (dev_id_ff[s] == {1'b0, req_chan.device}) begin
            dev_hit  = 1'b1;
            dev_base = dev_base_ff[s];
         end
      end
   end

   // cell chain
   bcl_pkg::entry_type    ent [N];
   bcl_pkg::entry_type    head;
   bcl_pkg::entry_type    head_new;
   bcl_pkg::cell_ctl_type ctl;

   assign head = ent[0];

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == N - 1) begin : g_tail
         bcl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (IDX_W'(i)),
            .ctl      (ctl),
            .nxt_in   (head_new),
            .head_in  (head_new),
            .ent_out  (ent[i])
         );
      end else begin : g_body
         bcl_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (IDX_W'(i)),
            .ctl      (ctl),
            .nxt_in   (ent[i+1]),
            .head_in  (head_new),
            .ent_out  (ent[i])
         );
      end
   end

   // sequencer registers
   state_type                   state_ff, state_in;
   logic [bcl_pkg::REQ_W-1:0]   op_ff, op_in;
   logic [bcl_pkg::DEV_W-1:0]   dev_ff, dev_in;
   logic [bcl_pkg::BLK_W-1:0]   blk_ff, blk_in;
   logic [bcl_pkg::SLOT_W-1:0]  idx_ff, idx_in;
   logic                        devok_ff, devok_in;
   logic [bcl_pkg::LBA_W-1:0]   base_ff, base_in;
   logic [IDX_W-1:0]            step_ff, step_in;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            hitpos_ff, hitpos_in;
   logic                        vict_ff, vict_in;
   logic [IDX_W-1:0]            victpos_ff, victpos_in;
   logic                        wb_pend_ff, wb_pend_in;
   logic [bcl_pkg::LBA_W-1:0]   wb_lba_ff, wb_lba_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic [bcl_pkg::CNT_W-1:0]   syncn_ff, syncn_in;
   logic [bcl_pkg::KIND_W-1:0]  fin_kind_ff, fin_kind_in;
   logic [bcl_pkg::SLOT_W-1:0]  fin_slot_ff, fin_slot_in;
   logic [bcl_pkg::LBA_W-1:0]   fin_lba_ff, fin_lba_in;
   logic [bcl_pkg::CNT_W-1:0]   fin_cnt_ff, fin_cnt_in;
   logic [bcl_pkg::ERR_W-1:0]   fin_err_ff, fin_err_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bcl_pkg::KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [bcl_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [bcl_pkg::LBA_W-1:0]   rsp_lba_ff, rsp_lba_in;
   logic [bcl_pkg::CNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;
   logic [bcl_pkg::ERR_W-1:0]   rsp_err_ff, rsp_err_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             emit;
   logic             last_step;
   logic             hit_now;
   logic             idx_match;
   logic [IDX_W-1:0] target;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign last_step = (step_ff == IDX_W'(N - 1));
   assign hit_now   = head.tvalid && (head.tdev == dev_ff) && (head.tblk == blk_ff);
   assign idx_match = (32'(idx_ff) < 32'(N)) && (IDX_W'(idx_ff) == head.id);
   assign target    = hit_ff ? hitpos_ff : victpos_ff;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      dev_in      = dev_ff;
      blk_in      = blk_ff;
      idx_in      = idx_ff;
      devok_in    = devok_ff;
      base_in     = base_ff;
      step_in     = step_ff;
      hit_in      = hit_ff;
      hitpos_in   = hitpos_ff;
      vict_in     = vict_ff;
      victpos_in  = victpos_ff;
      wb_pend_in  = wb_pend_ff;
      wb_lba_in   = wb_lba_ff;
      rd_pend_in  = rd_pend_ff;
      syncn_in    = syncn_ff;
      fin_kind_in = fin_kind_ff;
      fin_slot_in = fin_slot_ff;
      fin_lba_in  = fin_lba_ff;
      fin_cnt_in  = fin_cnt_ff;
      fin_err_in  = fin_err_ff;

      head_new    = head;
      ctl.step    = 1'b0;
      ctl.ins_pos = IDX_W'(N - 1);

      emit        = 1'b0;
      rsp_kind_in = bcl_pkg::KIND_GRANT;
      rsp_slot_in = '0;
      rsp_lba_in  = '0;
      rsp_cnt_in  = '0;
      rsp_err_in  = bcl_pkg::ERR_NONE;
      rsp_last_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in       = req_chan.req_type;
               dev_in      = req_chan.device;
               blk_in      = req_chan.block_number;
               idx_in      = req_chan.entry_index;
               devok_in    = dev_hit;
               base_in     = dev_base;
               step_in     = '0;
               hit_in      = 1'b0;
               vict_in     = 1'b0;
               wb_pend_in  = 1'b0;
               rd_pend_in  = 1'b0;
               syncn_in    = '0;
               fin_kind_in = bcl_pkg::KIND_ACK;
               fin_slot_in = '0;
               fin_lba_in  = '0;
               fin_cnt_in  = '0;
               fin_err_in  = bcl_pkg::ERR_NONE;
               case (req_chan.req_type) inside
                  bcl_pkg::REQ_GET, bcl_pkg::REQ_READ: begin
                     state_in = ST_SCAN;
                  end
                  bcl_pkg::REQ_DIRTY, bcl_pkg::REQ_RELEASE: begin
                     fin_slot_in = req_chan.entry_index;
                     state_in    = ST_UPD;
                  end
                  bcl_pkg::REQ_SYNC: begin
                     fin_kind_in = bcl_pkg::KIND_SYNC;
                     state_in    = ST_UPD;
                  end
                  default: begin
                     state_in = ST_EMIT_LAST;
                  end
               endcase
            end
         end

         // lookup pass: first tag match, last zero-count entry
         ST_SCAN: begin
            ctl.step = 1'b1;
            if (hit_now && !hit_ff) begin
               hit_in    = 1'b1;
               hitpos_in = step_ff;
            end
            if (head.cnt == '0) begin
               vict_in    = 1'b1;
               victpos_in = step_ff;
            end
            step_in = step_ff + 1'b1;
            if (last_step) begin
               step_in = '0;
               if (hit_in || (vict_in && devok_ff)) begin
                  state_in = ST_APPLY;
               end else begin
                  fin_kind_in = bcl_pkg::KIND_ERR;
                  fin_err_in  = vict_in ? bcl_pkg::ERR_NO_DEV : bcl_pkg::ERR_NO_FREE;
                  state_in    = ST_EMIT_LAST;
               end
            end
         end

         // update pass: hit or retag of the victim at the head
         ST_APPLY: begin
            ctl.step = 1'b1;
            if (step_ff == target) begin
               if (hit_ff) begin
                  if (head.cnt != '1) begin
                     head_new.cnt = head.cnt + 1'b1;
                  end
               end else begin
                  wb_pend_in      = head.ddirty;
                  wb_lba_in       = head.lba;
                  head_new.tvalid = 1'b1;
                  head_new.tdev   = dev_ff;
                  head_new.tblk   = blk_ff;
                  head_new.lba    = base_ff + bcl_pkg::LBA_W'(blk_ff);
                  head_new.dvalid = 1'b0;
                  head_new.ddirty = 1'b0;
                  head_new.cnt    = bcl_pkg::REF_W'(1);
               end
               if ((op_ff == bcl_pkg::REQ_READ) && !head_new.dvalid) begin
                  rd_pend_in      = 1'b1;
                  head_new.dvalid = 1'b1;
               end
               fin_kind_in = bcl_pkg::KIND_GRANT;
               fin_slot_in = bcl_pkg::SLOT_W'(head.id);
               fin_lba_in  = head_new.lba;
            end
            step_in = step_ff + 1'b1;
            if (last_step) begin
               step_in  = '0;
               state_in = ST_EMIT_WB;
            end
         end

         ST_EMIT_WB: begin
            if (!wb_pend_ff) begin
               state_in = ST_EMIT_RD;
            end else if (out_free) begin
               emit        = 1'b1;
               rsp_kind_in = bcl_pkg::KIND_WB;
               rsp_slot_in = fin_slot_ff;
               rsp_lba_in  = wb_lba_ff;
               state_in    = ST_EMIT_RD;
            end
         end

         ST_EMIT_RD: begin
            if (!rd_pend_ff) begin
               state_in = ST_EMIT_LAST;
            end else if (out_free) begin
               emit        = 1'b1;
               rsp_kind_in = bcl_pkg::KIND_RD;
               rsp_slot_in = fin_slot_ff;
               rsp_lba_in  = fin_lba_ff;
               state_in    = ST_EMIT_LAST;
            end
         end

         ST_EMIT_LAST: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_kind_in = fin_kind_ff;
               rsp_slot_in = fin_slot_ff;
               rsp_lba_in  = fin_lba_ff;
               rsp_cnt_in  = fin_cnt_ff;
               rsp_err_in  = fin_err_ff;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         // single pass for mark dirty, release and sync
         ST_UPD: begin
            if (!((op_ff == bcl_pkg::REQ_SYNC) && head.ddirty && !out_free)) begin
               ctl.step = 1'b1;
               case (op_ff)
                  bcl_pkg::REQ_DIRTY: begin
                     if (idx_match) begin
                        head_new.ddirty = 1'b1;
                     end
                  end
                  bcl_pkg::REQ_RELEASE: begin
                     if (idx_match && (head.cnt != '0)) begin
                        head_new.cnt = head.cnt - 1'b1;
                        if (head.cnt == bcl_pkg::REF_W'(1)) begin
                           // move to front: drop in behind the old tail
                           ctl.ins_pos = IDX_W'(N - 1) - step_ff;
                        end
                     end
                  end
                  bcl_pkg::REQ_SYNC: begin
                     if (head.ddirty) begin
                        emit            = 1'b1;
                        rsp_kind_in     = bcl_pkg::KIND_WB;
                        rsp_slot_in     = bcl_pkg::SLOT_W'(head.id);
                        rsp_lba_in      = head.lba;
                        head_new.ddirty = 1'b0;
                        head_new.dvalid = 1'b1;
                        syncn_in        = syncn_ff + 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               step_in = step_ff + 1'b1;
               if (last_step) begin
                  step_in    = '0;
                  fin_cnt_in = (op_ff == bcl_pkg::REQ_SYNC) ? syncn_in : '0;
                  state_in   = ST_EMIT_LAST;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register: loads on a new beat, drains on ready
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      dev_ff      <= dev_in;
      blk_ff      <= blk_in;
      idx_ff      <= idx_in;
      devok_ff    <= devok_in;
      base_ff     <= base_in;
      step_ff     <= step_in;
      hit_ff      <= hit_in;
      hitpos_ff   <= hitpos_in;
      vict_ff     <= vict_in;
      victpos_ff  <= victpos_in;
      wb_pend_ff  <= wb_pend_in;
      wb_lba_ff   <= wb_lba_in;
      rd_pend_ff  <= rd_pend_in;
      syncn_ff    <= syncn_in;
      fin_kind_ff <= fin_kind_in;
      fin_slot_ff <= fin_slot_in;
      fin_lba_ff  <= fin_lba_in;
      fin_cnt_ff  <= fin_cnt_in;
      fin_err_ff  <= fin_err_in;
      if (emit) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_slot_ff <= rsp_slot_in;
         rsp_lba_ff  <= rsp_lba_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_err_ff  <= rsp_err_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = rsp_kind_ff;
   assign rsp_chan.entry_slot  = rsp_slot_ff;
   assign rsp_chan.io_lba      = rsp_lba_ff;
   assign rsp_chan.dirty_count = rsp_cnt_ff;
   assign rsp_chan.error_code  = rsp_err_ff;
   assign rsp_chan.last        = rsp_last_ff;

endmodule

`default_nettype wire

FILE: verif/bcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcl_checker: prediction and comparison for the LRU block buffer cache
// Follows register writes and accepted request beats, keeps its own copy of
// the tags, flags, counts and recency list, and compares each response beat
// in order against the oldest predicted beat.
// ----------------------------------------------------------------------------

module bcl_checker (
   input  wire                             clock,
   input  wire                             reset,
   bcl_req_if                              req_mon,
   bcl_rsp_if                              rsp_mon,
   input  wire                             csr_wr_en,
   input  wire [bcl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [bcl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                              mismatches,
   output int                              beats_pending
);

   localparam int NE   = bcl_pkg::NUM_ENTRIES;
   localparam int ND   = bcl_pkg::NUM_DEVICES;
   localparam int HEAD = bcl_pkg::NUM_ENTRIES;

   typedef struct packed {
      logic [bcl_pkg::KIND_W-1:0] kind;
      logic [bcl_pkg::SLOT_W-1:0] slot;
      logic [bcl_pkg::LBA_W-1:0]  lba;
      logic [bcl_pkg::CNT_W-1:0]  cnt;
      logic [bcl_pkg::ERR_W-1:0]  err;
      logic                       last;
   } rsp_beat_type;

   rsp_beat_type     expected_beats[$];

   // predicted register file and entry state
   logic [bcl_pkg::ID_W-1:0]  slot_id   [ND];
   logic [bcl_pkg::LBA_W-1:0] slot_base [ND];
   logic                      tag_ok    [NE];
   logic [bcl_pkg::DEV_W-1:0] tag_dev   [NE];
   logic [bcl_pkg::BLK_W-1:0] tag_blk   [NE];
   logic [bcl_pkg::LBA_W-1:0] ent_lba   [NE];
   logic                      ent_valid [NE];
   logic                      ent_dirty [NE];
   logic [bcl_pkg::REF_W-1:0] ent_refs  [NE];
   int                        lru_next  [NE+1];
   int                        lru_prev  [NE+1];

   assign beats_pending = expected_beats.size();

   task automatic add_beat(input logic [bcl_pkg::KIND_W-1:0] kind, input int slot,
                           input logic [bcl_pkg::LBA_W-1:0] lba, input int cnt,
                           input logic [bcl_pkg::ERR_W-1:0] err, input logic last);
      rsp_beat_type b;
      b.kind = kind; b.slot = slot[bcl_pkg::SLOT_W-1:0]; b.lba = lba;
      b.cnt = cnt[bcl_pkg::CNT_W-1:0]; b.err = err; b.last = last;
      expected_beats.push_back(b);
   endtask

   task automatic move_to_front(input int e);
      int first;
      first = lru_next[HEAD];
      lru_next[e] = first;
      lru_prev[e] = HEAD;
      lru_prev[first] = e;
      lru_next[HEAD] = e;
   endtask

   task automatic clear_state();
      for (int s = 0; s < ND; s++) begin
         slot_id[s] = bcl_pkg::DEV_UNUSED;
         slot_base[s] = '0;
      end
      for (int i = 0; i < NE; i++) begin
         tag_ok[i] = 1'b0; tag_dev[i] = '0; tag_blk[i] = '0; ent_lba[i] = '0;
         ent_valid[i] = 1'b0; ent_dirty[i] = 1'b0; ent_refs[i] = '0;
      end
      lru_next[HEAD] = HEAD;
      lru_prev[HEAD] = HEAD;
      for (int i = 0; i < NE; i++) move_to_front(i);
      expected_beats.delete();
   endtask

   // tag lookup from the front, victim from the back, then the response set
   task automatic predict_block(input logic is_read,
                                input logic [bcl_pkg::DEV_W-1:0] dev,
                                input logic [bcl_pkg::BLK_W-1:0] blk);
      int e, cur, s;
      e = -1;
      cur = lru_next[HEAD];
      for (int n = 0; n < NE && cur < NE && e < 0; n++) begin
         if (tag_ok[cur] && tag_dev[cur] == dev && tag_blk[cur] == blk) e = cur;
         cur = lru_next[cur];
      end
      if (e >= 0) begin
         if (ent_refs[e] != 8'd255) ent_refs[e]++;
      end else begin
         cur = lru_prev[HEAD];
         for (int n = 0; n < NE && cur < NE && e < 0; n++) begin
            if (ent_refs[cur] == 0) e = cur;
            cur = lru_prev[cur];
         end
         if (e < 0) begin
            add_beat(bcl_pkg::KIND_ERR, 0, '0, 0, bcl_pkg::ERR_NO_FREE, 1'b1);
            return;
         end
         s = -1;
         for (int k = ND - 1; k >= 0; k--)
            if (int'($signed(slot_id[k])) == int'(dev)) s = k;
         if (s < 0) begin
            add_beat(bcl_pkg::KIND_ERR, 0, '0, 0, bcl_pkg::ERR_NO_DEV, 1'b1);
            return;
         end
         if (ent_dirty[e])
            add_beat(bcl_pkg::KIND_WB, e, ent_lba[e], 0, bcl_pkg::ERR_NONE, 1'b0);
         tag_ok[e] = 1'b1;
         tag_dev[e] = dev;
         tag_blk[e] = blk;
         ent_lba[e] = slot_base[s] + {16'd0, blk};
         ent_valid[e] = 1'b0;
         ent_dirty[e] = 1'b0;
         ent_refs[e] = 8'd1;
      end
      if (is_read && !ent_valid[e]) begin
         add_beat(bcl_pkg::KIND_RD, e, ent_lba[e], 0, bcl_pkg::ERR_NONE, 1'b0);
         ent_valid[e] = 1'b1;
      end
      add_beat(bcl_pkg::KIND_GRANT, e, ent_lba[e], 0, bcl_pkg::ERR_NONE, 1'b1);
   endtask

   task automatic predict_request(input logic [bcl_pkg::REQ_W-1:0] rtype,
                                  input logic [bcl_pkg::DEV_W-1:0] dev,
                                  input logic [bcl_pkg::BLK_W-1:0] blk,
                                  input logic [bcl_pkg::SLOT_W-1:0] idx);
      int cur, nwb, p, n;
      case (rtype)
         bcl_pkg::REQ_GET, bcl_pkg::REQ_READ:
            predict_block(rtype == bcl_pkg::REQ_READ, dev, blk);
         bcl_pkg::REQ_DIRTY: begin
            ent_dirty[idx] = 1'b1;
            add_beat(bcl_pkg::KIND_ACK, idx, '0, 0, bcl_pkg::ERR_NONE, 1'b1);
         end
         bcl_pkg::REQ_RELEASE: begin
            if (ent_refs[idx] != 0) begin
               ent_refs[idx]--;
               if (ent_refs[idx] == 0) begin
                  p = lru_prev[idx];
                  n = lru_next[idx];
                  lru_next[p] = n;
                  lru_prev[n] = p;
                  move_to_front(idx);
               end
            end
            add_beat(bcl_pkg::KIND_ACK, idx, '0, 0, bcl_pkg::ERR_NONE, 1'b1);
         end
         bcl_pkg::REQ_SYNC: begin
            nwb = 0;
            cur = lru_next[HEAD];
            for (int k = 0; k < NE && cur < NE; k++) begin
               if (ent_dirty[cur]) begin
                  add_beat(bcl_pkg::KIND_WB, cur, ent_lba[cur], 0, bcl_pkg::ERR_NONE, 1'b0);
                  ent_dirty[cur] = 1'b0;
                  ent_valid[cur] = 1'b1;
                  nwb++;
               end
               cur = lru_next[cur];
            end
            add_beat(bcl_pkg::KIND_SYNC, 0, '0, nwb, bcl_pkg::ERR_NONE, 1'b1);
         end
         default: add_beat(bcl_pkg::KIND_ACK, 0, '0, 0, bcl_pkg::ERR_NONE, 1'b1);
      endcase
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   initial mismatches = 0;

   // response beats are compared before the request of the same edge is
   // predicted; a request never produces a beat on its own accept edge
   always @(posedge clock) begin
      rsp_beat_type got, want;
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.kind, rsp_mon.entry_slot, rsp_mon.io_lba,
                    rsp_mon.dirty_count, rsp_mon.error_code, rsp_mon.last};
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat %p", got));
            end else begin
               want = expected_beats.pop_front();
               if (got.kind != want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
               if (got.slot != want.slot)
                  report_mismatch($sformatf("entry_slot %0d, want %0d",
                                            got.slot, want.slot));
               if (got.lba != want.lba)
                  report_mismatch($sformatf("io_lba %h, want %h", got.lba, want.lba));
               if (got.cnt != want.cnt)
                  report_mismatch($sformatf("dirty_count %0d, want %0d",
                                            got.cnt, want.cnt));
               if (got.err != want.err)
                  report_mismatch($sformatf("error_code %0d, want %0d",
                                            got.err, want.err));
               if (got.last != want.last)
                  report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_request(req_mon.req_type, req_mon.device, req_mon.block_number,
                            req_mon.entry_index);
         if (csr_wr_en) begin
            if (csr_index < bcl_pkg::CSR_DEV0_BASE)
               slot_id[csr_index] = csr_wdata[bcl_pkg::ID_W-1:0];
            else
               slot_base[csr_index - bcl_pkg::CSR_DEV0_BASE] = csr_wdata;
         end
      end
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the LRU block buffer cache
// Drives directed and random requests in bursts through several register
// settings, stalls the response side on a changing pattern, and leaves all
// checking to the checker beside the block. A watchdog ends a stuck run.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int NE             = bcl_pkg::NUM_ENTRIES;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [bcl_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bcl_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   int                             mismatches, beats_pending;
   int                             burst_left = 0;
   int                             quiet_cycles = 0;
   logic [NE-1:0]                  entry_tagged = '0;
   logic [bcl_pkg::SLOT_W-1:0]     last_grant = '0;
   logic [15:0]                    stall_pattern = 16'hFFFF;
   int                             pattern_age = 0;

   bcl_req_if req_bus();
   bcl_rsp_if rsp_bus();

   initial begin
      req_bus.valid = 1'b0; req_bus.req_type = '0; req_bus.device = '0;
      req_bus.block_number = '0; req_bus.entry_index = '0;
      rsp_bus.ready = 1'b0;
   end

   always #6 clock = ~clock;

   block_buffer_cache_lru uut (
      .clock(clock), .reset(reset), .req_chan(req_bus), .rsp_chan(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bcl_checker chk (
      .clock(clock), .reset(reset), .req_mon(req_bus), .rsp_mon(rsp_bus),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .beats_pending(beats_pending)
   );

   // receiver stall pattern, reshuffled now and then, sometimes never stalls
   always @(posedge clock) begin
      if (pattern_age == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern <= 16'hFFFF;
            1: stall_pattern <= 16'($urandom()) | 16'h0101;
            default: stall_pattern <= 16'($urandom()) | 16'h8000;
         endcase
         pattern_age <= $urandom_range(20, 200);
      end else begin
         stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
         pattern_age <= pattern_age - 1;
      end
      rsp_bus.ready <= stall_pattern[15];
   end

   // grant tracking for safe mark-dirty picks, and the watchdog
   always @(posedge clock) begin
      if (reset) begin
         entry_tagged <= '0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready && rsp_bus.kind == bcl_pkg::KIND_GRANT) begin
            entry_tagged[rsp_bus.entry_slot] <= 1'b1;
            last_grant <= rsp_bus.entry_slot;
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // one request beat; a gap lowers valid before the next burst starts
   task automatic send_req(input logic [bcl_pkg::REQ_W-1:0] rtype,
                           input logic [bcl_pkg::DEV_W-1:0] dev,
                           input logic [bcl_pkg::BLK_W-1:0] blk,
                           input logic [bcl_pkg::SLOT_W-1:0] idx);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= rtype;
      req_bus.device <= dev;
      req_bus.block_number <= blk;
      req_bus.entry_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
   endtask

   // stop sending until every predicted beat is back, then let the block settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (beats_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all eight registers, one per cycle, only while drained
   task automatic write_regs(input logic [7:0] ids[4], input logic [47:0] bases[4]);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= i[bcl_pkg::CSR_IDX_W-1:0];
         csr_wdata <= (i < 4) ? {40'd0, ids[i]} : bases[i-4];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [bcl_pkg::SLOT_W-1:0] pick_tagged();
      logic [bcl_pkg::SLOT_W-1:0] e;
      e = bcl_pkg::SLOT_W'($urandom_range(0, NE - 1));
      for (int t = 0; t < 64 && !entry_tagged[e]; t++)
         e = bcl_pkg::SLOT_W'($urandom_range(0, NE - 1));
      return e;
   endfunction

   task automatic random_item();
      int pick;
      logic [bcl_pkg::DEV_W-1:0]  dev;
      logic [bcl_pkg::BLK_W-1:0]  blk;
      logic [bcl_pkg::SLOT_W-1:0] e;
      logic [bcl_pkg::DEV_W-1:0]  any_dev;
      logic [bcl_pkg::SLOT_W-1:0] any_idx;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
         0: dev = 7'd0;
         1: dev = 7'd127;
         2: dev = 7'd5;
         3: dev = 7'd42;
         default: dev = bcl_pkg::DEV_W'($urandom_range(0, 127));
      endcase
      blk = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 15);
      any_dev = bcl_pkg::DEV_W'($urandom());
      any_idx = bcl_pkg::SLOT_W'($urandom_range(0, 31));
      if (pick < 40) begin
         send_req(pick < 20 ? bcl_pkg::REQ_GET : bcl_pkg::REQ_READ, dev, blk, any_idx);
      end else if (pick < 72) begin
         send_req(bcl_pkg::REQ_RELEASE, any_dev, $urandom(), any_idx);
      end else if (pick < 86) begin
         e = pick_tagged();
         if (entry_tagged[e]) send_req(bcl_pkg::REQ_DIRTY, any_dev, $urandom(), e);
         else send_req(bcl_pkg::REQ_RELEASE, any_dev, $urandom(), e);
      end else if (pick < 94) begin
         send_req(bcl_pkg::REQ_SYNC, any_dev, $urandom(), any_idx);
      end else begin
         send_req(bcl_pkg::REQ_W'($urandom_range(5, 7)), any_dev, $urandom(), any_idx);
      end
   endtask

   initial begin
      logic [7:0]  ids[4];
      logic [47:0] bases[4];
      logic [bcl_pkg::SLOT_W-1:0] held_slot;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: no slot registered
      send_req(bcl_pkg::REQ_GET, 7'd0, 32'd0, 5'd0);
      send_req(bcl_pkg::REQ_READ, 7'd127, 32'hFFFF_FFFF, 5'd31);
      send_req(bcl_pkg::REQ_SYNC, 7'd0, 32'd0, 5'd0);
      send_req(bcl_pkg::REQ_RELEASE, 7'd0, 32'd0, 5'd0);
      send_req(3'd5, 7'd0, 32'd0, 5'd0);
      send_req(3'd7, 7'h7F, 32'hFFFF_FFFF, 5'h1F);
      drain();

      // duplicate id in slot 3 never wins over slot 0; slot 1 wraps its LBA
      ids = '{8'd0, 8'd127, bcl_pkg::DEV_UNUSED, 8'd0};
      bases = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'h1234_5678_9ABC, 48'd5};
      write_regs(ids, bases);

      send_req(bcl_pkg::REQ_GET, 7'd0, 32'd0, 5'd0);
      send_req(bcl_pkg::REQ_READ, 7'd0, 32'd0, 5'd0);
      send_req(bcl_pkg::REQ_READ, 7'd127, 32'hFFFF_FFFF, 5'd0);
      send_req(bcl_pkg::REQ_GET, 7'd127, 32'd1, 5'd0);
      send_req(bcl_pkg::REQ_GET, 7'd64, 32'd9, 5'd0);
      drain();
      send_req(bcl_pkg::REQ_DIRTY, 7'd0, 32'd0, last_grant);
      send_req(bcl_pkg::REQ_RELEASE, 7'd0, 32'd0, last_grant);
      send_req(bcl_pkg::REQ_SYNC, 7'd0, 32'd0, 5'd0);
      send_req(3'd6, 7'd0, 32'd0, 5'd0);
      drain();

      // repeated hits, then released past zero
      send_req(bcl_pkg::REQ_GET, 7'd0, 32'd77, 5'd0);
      drain();
      held_slot = last_grant;
      for (int i = 0; i < 3; i++) send_req(bcl_pkg::REQ_GET, 7'd0, 32'd77, 5'd0);
      for (int i = 0; i < 5; i++) send_req(bcl_pkg::REQ_RELEASE, 7'd0, 32'd0, held_slot);

      // exhaust the free entries, then let them all go
      for (int i = 0; i < 34; i++)
         send_req(bcl_pkg::REQ_GET, 7'd0, 32'(1000 + i), 5'd0);
      for (int r = 0; r < 2; r++)
         for (int i = 0; i < NE; i++)
            send_req(bcl_pkg::REQ_RELEASE, 7'd0, 32'd0, bcl_pkg::SLOT_W'(i));

      // dirty victims on miss
      for (int i = 0; i < 6; i++)
         send_req(bcl_pkg::REQ_DIRTY, 7'd0, 32'd0, pick_tagged());
      for (int i = 0; i < 6; i++)
         send_req(bcl_pkg::REQ_READ, 7'd127, 32'(2000 + i), 5'd0);
      drain();

      // random part, first setting
      for (int i = 0; i < 36; i++) random_item();
      drain();

      ids = '{bcl_pkg::DEV_UNUSED, 8'd5, 8'd42, 8'd127};
      bases = '{48'd0, {$urandom(), 16'h0}, 48'hFFFF_FFFF_FFF0, {16'h0, $urandom()}};
      write_regs(ids, bases);
      for (int i = 0; i < 30; i++) random_item();
      drain();

      // wide ids and bases in every slot
      ids = '{8'd0, 8'd42, 8'd127, 8'd5};
      bases = '{{$urandom(), 16'hFFFF}, 48'hFFFF_FFFF_FFFF, 48'd0, {$urandom(), 16'h0}};
      write_regs(ids, bases);
      for (int i = 0; i < 20; i++) random_item();
      drain();

      if (mismatches == 0 && beats_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
